// ===== rtl/strmin_pkg.sv =====
// Shared types and constants for the sparse-table range minimum unit.
// Used by the interfaces, the front, the command queue and the back end.
package strmin_pkg;

    localparam int ENTRIES_DEF    = 1024;
    localparam int LEVELS_DEF     = 11;
    localparam int VALUE_BITS_DEF = 16;

    localparam int OP_W    = 2;
    localparam int POS_W   = 10;
    localparam int CNT_W   = 11;
    localparam int DATA_W  = 16;
    localparam int LVL_W   = 5;
    localparam int SPAN_W  = 12;
    localparam int Q_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_BUILD = 2'd1,
        KIND_QUERY = 2'd2
    } cmd_kind_t;

    // Classified command handed from the front to the back end.
    typedef struct packed {
        cmd_kind_t          kind;
        logic               bad;
        logic [LVL_W-1:0]   lvl;
        logic [POS_W-1:0]   pos_a;
        logic [POS_W-1:0]   pos_b;
        logic [DATA_W-1:0]  data;
        logic [CNT_W-1:0]   count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/strmin_cmd_if.sv =====
// Input channel of the range minimum unit: valid/ready plus the item fields.
// Depends on strmin_pkg for field widths.
interface strmin_cmd_if;
    import strmin_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  index;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  right;

    modport source (output valid, operation, index, value, count, left, right, input ready);
    modport sink   (input valid, operation, index, value, count, left, right, output ready);
endinterface

// ===== rtl/strmin_res_if.sv =====
// Result channel of the range minimum unit: valid/ready plus minimum and status.
// Depends on strmin_pkg for field widths.
interface strmin_res_if;
    import strmin_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] minimum;
    logic              status;

    modport source (output valid, minimum, status, input ready);
    modport sink   (input valid, minimum, status, output ready);
endinterface

// ===== rtl/strmin_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module strmin_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/strmin_front.sv =====
// Front end: accepts items, drops no-ops and out-of-range loads, checks query
// bounds against the built count and picks the block level. Uses strmin_pkg.
module strmin_front #(
    parameter int ENTRIES = strmin_pkg::ENTRIES_DEF,
    parameter int LEVELS  = strmin_pkg::LEVELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    strmin_cmd_if.sink          cmd,
    input  strmin_pkg::q_stat_t q_stat,
    output logic                push,
    output strmin_pkg::cmd_t    push_cmd
);
    import strmin_pkg::*;

    logic [CNT_W-1:0] built_reg;
    logic [CNT_W-1:0] built_next;
    logic             keep;
    logic [CNT_W-1:0] len;
    logic [LVL_W-1:0] k;
    logic [CNT_W-1:0] sat_count;
    logic [CNT_W-1:0] end_b;

    assign cmd.ready = !q_stat.full;
    assign push      = cmd.valid && cmd.ready && keep;

    assign sat_count = (32'(cmd.count) > ENTRIES) ? CNT_W'(ENTRIES) : cmd.count;
    assign len       = CNT_W'(cmd.right) - CNT_W'(cmd.left) + CNT_W'(1);

    always_comb
    begin
        k = '0;
        for (int b = 0; b < CNT_W; b++)
        begin
            if (len[b])
            begin
                k = LVL_W'(b);
            end
        end
        if (32'(k) > LEVELS - 1)
        begin
            k = LVL_W'(LEVELS - 1);
        end
    end

    assign end_b = CNT_W'(cmd.right) + CNT_W'(1) - (CNT_W'(1) << k);

    always_comb
    begin
        keep       = 1'b0;
        built_next = built_reg;
        push_cmd   = '0;
        push_cmd.lvl   = k;
        push_cmd.pos_a = (cmd.operation == OP_LOAD) ? cmd.index : cmd.left;
        push_cmd.pos_b = end_b[POS_W-1:0];
        push_cmd.data  = cmd.value;
        push_cmd.count = sat_count;
        unique case (cmd.operation)
            OP_LOAD:
            begin
                push_cmd.kind = KIND_LOAD;
                keep = (32'(cmd.index) < ENTRIES);
            end
            OP_BUILD:
            begin
                push_cmd.kind = KIND_BUILD;
                keep = 1'b1;
                built_next = sat_count;
            end
            OP_QUERY:
            begin
                push_cmd.kind = KIND_QUERY;
                push_cmd.bad  = (cmd.left > cmd.right) || (CNT_W'(cmd.right) >= built_reg);
                keep = 1'b1;
            end
            default:
            begin
                push_cmd.kind = KIND_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            built_reg <= '0;
        end
        else if (push)
        begin
            built_reg <= built_next;
        end
    end
endmodule

// ===== rtl/strmin_fifo.sv =====
// Short command queue between front and back end.
// Uses strmin_pkg for the command type and depth.
module strmin_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  strmin_pkg::cmd_t    push_cmd,
    input  logic                pop,
    output strmin_pkg::cmd_t    head,
    output strmin_pkg::q_stat_t q_stat
);
    import strmin_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CT_W  = $clog2(Q_DEPTH + 1);

    cmd_t             mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CT_W-1:0]  cnt_reg;

    assign head         = mem_reg[rd_reg];
    assign q_stat.full  = (cnt_reg == CT_W'(Q_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (32'(wr_reg) == Q_DEPTH - 1) ? '0 : wr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= (32'(rd_reg) == Q_DEPTH - 1) ? '0 : rd_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CT_W'(1);
            end
        end
    end
endmodule

// ===== rtl/strmin_back.sv =====
// Back end: runs loads, table builds and queries against the level table RAM
// and holds the result register. Uses strmin_pkg and strmin_ram.
module strmin_back #(
    parameter int ENTRIES    = strmin_pkg::ENTRIES_DEF,
    parameter int LEVELS     = strmin_pkg::LEVELS_DEF,
    parameter int VALUE_BITS = strmin_pkg::VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  strmin_pkg::cmd_t    head,
    input  strmin_pkg::q_stat_t q_stat,
    output logic                pop,
    strmin_res_if.source        res
);
    import strmin_pkg::*;

    localparam int DEPTH = LEVELS * ENTRIES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_Q_B   = 8'b0000_0010,
        S_Q_C   = 8'b0000_0100,
        S_B_LVL = 8'b0000_1000,
        S_B_RA  = 8'b0001_0000,
        S_B_RB  = 8'b0010_0000,
        S_B_WR  = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [LVL_W-1:0]      j_reg, j_next;
    logic [SPAN_W-1:0]     span_reg, span_next;
    logic [CNT_W-1:0]      i_reg, i_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic [POS_W-1:0]      pos_b_reg, pos_b_next;
    logic [VALUE_BITS-1:0] a_reg, a_next;
    logic                  vld_reg, vld_next;
    logic [DATA_W-1:0]     min_reg, min_next;
    logic                  st_reg, st_next;

    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [VALUE_BITS-1:0] wdata, rdata, low;
    logic                  slot_free;
    logic [SPAN_W-1:0]     half;

    function automatic logic [AW-1:0] addr_of(input logic [LVL_W-1:0] lvl,
                                              input logic [CNT_W-1:0] pos);
        return AW'(lvl) * AW'(ENTRIES) + AW'(pos);
    endfunction

    strmin_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign slot_free   = !vld_reg || res.ready;
    assign half        = span_reg >> 1;
    assign low         = (a_reg < rdata) ? a_reg : rdata;
    assign res.valid   = vld_reg;
    assign res.minimum = min_reg;
    assign res.status  = st_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        span_next  = span_reg;
        i_next     = i_reg;
        lvl_next   = lvl_reg;
        pos_b_next = pos_b_reg;
        a_next     = a_reg;
        vld_next   = vld_reg && !res.ready;
        min_next   = min_reg;
        st_next    = st_reg;
        pop        = 1'b0;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = addr_of(LVL_W'(0), CNT_W'(head.pos_a));
        wdata      = VALUE_BITS'(head.data);
        raddr      = addr_of(head.lvl, CNT_W'(head.pos_a));
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    case (head.kind)
                        KIND_LOAD:
                        begin
                            we  = 1'b1;
                            pop = 1'b1;
                        end
                        KIND_BUILD:
                        begin
                            pop        = 1'b1;
                            n_next     = head.count;
                            j_next     = LVL_W'(1);
                            span_next  = SPAN_W'(2);
                            state_next = S_B_LVL;
                        end
                        KIND_QUERY:
                        begin
                            if (head.bad)
                            begin
                                if (slot_free)
                                begin
                                    pop      = 1'b1;
                                    vld_next = 1'b1;
                                    min_next = '0;
                                    st_next  = 1'b1;
                                end
                            end
                            else
                            begin
                                re         = 1'b1;
                                pop        = 1'b1;
                                lvl_next   = head.lvl;
                                pos_b_next = head.pos_b;
                                state_next = S_Q_B;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            S_Q_B:
            begin
                re         = 1'b1;
                raddr      = addr_of(lvl_reg, CNT_W'(pos_b_reg));
                a_next     = rdata;
                state_next = S_Q_C;
            end
            S_Q_C:
            begin
                // hold until the result register frees up
                if (slot_free)
                begin
                    vld_next   = 1'b1;
                    min_next   = DATA_W'(low);
                    st_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_B_LVL:
            begin
                if ((32'(j_reg) < LEVELS) && (span_reg <= SPAN_W'(n_reg)))
                begin
                    i_next     = '0;
                    state_next = S_B_RA;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_B_RA:
            begin
                if (SPAN_W'(i_reg) + span_reg <= SPAN_W'(n_reg))
                begin
                    re         = 1'b1;
                    raddr      = addr_of(j_reg - LVL_W'(1), i_reg);
                    state_next = S_B_RB;
                end
                else
                begin
                    // advance to the next level
                    j_next     = j_reg + LVL_W'(1);
                    span_next  = span_reg << 1;
                    state_next = S_B_LVL;
                end
            end
            S_B_RB:
            begin
                re         = 1'b1;
                raddr      = addr_of(j_reg - LVL_W'(1), i_reg + CNT_W'(half));
                a_next     = rdata;
                state_next = S_B_WR;
            end
            S_B_WR:
            begin
                we         = 1'b1;
                waddr      = addr_of(j_reg, i_reg);
                wdata      = low;
                i_next     = i_reg + CNT_W'(1);
                state_next = S_B_RA;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        j_reg     <= j_next;
        span_reg  <= span_next;
        i_reg     <= i_next;
        lvl_reg   <= lvl_next;
        pos_b_reg <= pos_b_next;
        a_reg     <= a_next;
        min_reg   <= min_next;
        st_reg    <= st_next;
    end
endmodule

// ===== rtl/sparse_table_range_min_unit.sv =====
// Sparse-table range minimum unit. Load items write level 0 of the table, a
// build fills the upper levels, a query returns the minimum of two overlapping
// power-of-two blocks or a bad-range status. All table traffic goes through
// one RAM with a single read port: a load makes one write, a valid query two
// reads and then the compare, a bad-range query no table access, and a build
// two reads of the level below for each entry that it writes.
// A two-entry queue sits between the front and the back end, so items are
// accepted while the back end works or a result waits to be taken, until the
// queue fills. The table needs no clearing pass after reset.
module sparse_table_range_min_unit #(
    parameter int ENTRIES    = strmin_pkg::ENTRIES_DEF,
    parameter int LEVELS     = strmin_pkg::LEVELS_DEF,
    parameter int VALUE_BITS = strmin_pkg::VALUE_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    strmin_cmd_if.sink   cmd,
    strmin_res_if.source res
);
    import strmin_pkg::*;

    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    cmd_t    head;
    q_stat_t q_stat;

    strmin_front #(.ENTRIES(ENTRIES), .LEVELS(LEVELS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    strmin_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    strmin_back #(
        .ENTRIES    (ENTRIES),
        .LEVELS     (LEVELS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .res    (res)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("command popped from an empty queue");

    a_q_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue flags full and empty together");
endmodule

// ===== tb/tb_sparse_table_range_min_unit.sv =====
// Testbench for sparse_table_range_min_unit: loads, builds and range queries
// checked against an in-bench sparse-table predictor. Uses strmin_pkg and the
// strmin_cmd_if / strmin_res_if channel interfaces.
`timescale 1ns / 100ps

module tb_sparse_table_range_min_unit;
    import strmin_pkg::*;

    localparam int NUM_ENTRIES = ENTRIES_DEF;
    localparam int NUM_LEVELS  = LEVELS_DEF;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [DATA_W-1:0] minimum;
        logic              status;
    } min_result_t;

    logic clk;
    logic rst_n;
    strmin_cmd_if cmd ();
    strmin_res_if res ();

    sparse_table_range_min_unit dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .res  (res)
    );

    // predictor state
    logic [DATA_W-1:0] level_mem [NUM_LEVELS][NUM_ENTRIES];
    logic [CNT_W-1:0]  cover_count;
    bit                written [NUM_ENTRIES];
    int                filled_prefix;

    min_result_t pending_mins [$];
    int          error_count;
    int          cycle_count;
    bit          steady;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic void predict_build(input logic [CNT_W-1:0] n_in);
        int n;
        int span;
        n = (n_in > NUM_ENTRIES) ? NUM_ENTRIES : int'(n_in);
        cover_count = CNT_W'(n);
        for (int j = 1; j < NUM_LEVELS && (1 << j) <= n; j++) begin
            span = 1 << j;
            for (int i = 0; i + span <= n; i++) begin
                level_mem[j][i] = (level_mem[j-1][i] < level_mem[j-1][i + span/2]) ?
                                  level_mem[j-1][i] : level_mem[j-1][i + span/2];
            end
        end
    endfunction

    function automatic min_result_t predict_query(input int lo, input int hi);
        min_result_t r;
        int k;
        int len;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        k = 0;
        if (lo > hi || hi >= int'(cover_count)) begin
            r.minimum = '0;
            r.status  = 1'b1;
            return r;
        end
        len = hi - lo + 1;
        while (k + 1 < NUM_LEVELS && (1 << (k + 1)) <= len)
            k++;
        a = level_mem[k][lo];
        b = level_mem[k][hi + 1 - (1 << k)];
        r.minimum = (a < b) ? a : b;
        r.status  = 1'b0;
        return r;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input int idx, input int val,
                             input int cnt, input int lo, input int hi);
        while (!steady && $urandom_range(99) < 7) begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.operation <= op;
        cmd.index     <= POS_W'(idx);
        cmd.value     <= DATA_W'(val);
        cmd.count     <= CNT_W'(cnt);
        cmd.left      <= POS_W'(lo);
        cmd.right     <= POS_W'(hi);
        do @(posedge clk); while (!cmd.ready);
        case (op)
            OP_LOAD:
            begin
                level_mem[0][idx] = DATA_W'(val);
                written[idx] = 1'b1;
                while (filled_prefix < NUM_ENTRIES && written[filled_prefix])
                    filled_prefix++;
            end
            OP_BUILD: predict_build(CNT_W'(cnt));
            OP_QUERY: pending_mins.push_back(predict_query(lo, hi));
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic send_load(input int idx, input int val);
        send_item(OP_LOAD, idx, val, $urandom_range(2047), $urandom_range(1023),
                  $urandom_range(1023));
    endtask

    task automatic send_build(input int cnt);
        send_item(OP_BUILD, $urandom_range(1023), $urandom_range(65535), cnt,
                  $urandom_range(1023), $urandom_range(1023));
    endtask

    task automatic send_query(input int lo, input int hi);
        send_item(OP_QUERY, $urandom_range(1023), $urandom_range(65535),
                  $urandom_range(2047), lo, hi);
    endtask

    // a query that mostly lands inside the built range
    task automatic send_random_query();
        int lo;
        int hi;
        if (cover_count > 0 && $urandom_range(99) < 85) begin
            hi = $urandom_range(int'(cover_count) - 1);
            lo = $urandom_range(hi);
        end else begin
            lo = $urandom_range(1023);
            hi = $urandom_range(1023);
        end
        send_query(lo, hi);
    endtask

    task automatic test_directed();
        send_query(0, 0);
        send_load(0, 16'hFFFF);
        send_load(1, 0);
        for (int i = 2; i < 8; i++)
            send_load(i, 100 * i + 7);
        send_item(OP_NOP, 1023, 16'hFFFF, 2047, 1023, 1023);
        send_build(8);
        send_query(0, 0);
        send_query(0, 7);
        send_query(2, 7);
        send_query(3, 5);
        send_query(5, 3);
        send_query(0, 8);
        send_query(1023, 1023);
        // level 0 changes, upper levels keep the old build
        send_load(1, 16'h8000);
        send_query(0, 1);
        send_query(1, 1);
        send_build(0);
        send_query(0, 0);
        send_build(8);
        send_query(0, 7);
    endtask

    task automatic test_random_small(input int n_items);
        int lim;
        for (int t = 0; t < n_items; t++) begin
            steady = (t >= n_items / 3 && t < n_items / 2);
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    lim = (filled_prefix < 80) ? filled_prefix : 79;
                    if ($urandom_range(9) == 0)
                        send_load($urandom_range(1023), $urandom_range(65535));
                    else
                        send_load($urandom_range(lim), $urandom_range(65535));
                end
                3:
                begin
                    lim = (filled_prefix < 70) ? filled_prefix : 70;
                    send_build($urandom_range(lim));
                end
                4:
                    send_item(OP_NOP, $urandom_range(1023), $urandom_range(65535),
                              $urandom_range(2047), $urandom_range(1023),
                              $urandom_range(1023));
                default: send_random_query();
            endcase
        end
        steady = 1'b0;
    endtask

    task automatic test_full_table();
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (!written[i])
                send_load(i, $urandom_range(65535));
        send_build($urandom_range(2047, NUM_ENTRIES + 1));
        send_query(0, NUM_ENTRIES - 1);
        send_query(1, NUM_ENTRIES - 1);
        for (int t = 0; t < 40; t++)
            send_random_query();
        send_load(512, 0);
        send_build(NUM_ENTRIES);
        send_query(0, NUM_ENTRIES - 1);
        for (int t = 0; t < 40; t++)
            send_random_query();
    endtask

    always @(negedge clk)
        if (rst_n)
            res.ready <= steady || ($urandom_range(99) >= 7);

    always @(posedge clk) begin
        min_result_t want;
        if (rst_n && res.valid && res.ready) begin
            if (pending_mins.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = pending_mins.pop_front();
                if (res.minimum !== want.minimum)
                    report_mismatch($sformatf("minimum %0h, want %0h",
                                              res.minimum, want.minimum));
                if (res.status !== want.status)
                    report_mismatch($sformatf("status %0b, want %0b",
                                              res.status, want.status));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        rst_n         = 1'b0;
        steady        = 1'b0;
        cmd.valid     = 1'b0;
        cmd.operation = OP_NOP;
        cmd.index     = '0;
        cmd.value     = '0;
        cmd.count     = '0;
        cmd.left      = '0;
        cmd.right     = '0;
        res.ready     = 1'b0;
        cover_count   = '0;
        filled_prefix = 0;
        error_count   = 0;
        cycle_count   = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_small(600);
        test_full_table();
        cmd.valid <= 1'b0;
        while (pending_mins.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/strmin_pkg.sv
rtl/strmin_cmd_if.sv
rtl/strmin_res_if.sv
rtl/strmin_ram.sv
rtl/strmin_front.sv
rtl/strmin_fifo.sv
rtl/strmin_back.sv
rtl/sparse_table_range_min_unit.sv
tb/tb_sparse_table_range_min_unit.sv
